// ===== sv/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

	// sizes of the kept list and of one coordinate
	localparam int MAX_KEPT = 128;
	localparam int COORD_W  = 16;

	// fixed field widths on the ports
	localparam int FIELD_W = 16;
	localparam int SCORE_W = 16;
	localparam int LABEL_W = 8;
	localparam int THR_W   = 16;
	localparam int MAXC_W  = 8;
	localparam int SEEN_W  = 8;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W   = $clog2(MAX_KEPT + 1);
	localparam int LEN_W   = COORD_W;
	localparam int AREA_W  = 2 * COORD_W;
	localparam int UNION_W = AREA_W + 1;
	localparam int LHS_W   = AREA_W + THR_W;
	localparam int RHS_W   = UNION_W + THR_W;

	localparam int PAYLOAD_W = 4 * FIELD_W + SCORE_W + LABEL_W;
	localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(29491);
	localparam logic [MAXC_W-1:0] MAXC_RESET = MAXC_W'(100);
	localparam logic [SEEN_W-1:0] SEEN_MAX   = {SEEN_W{1'b1}};

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IOU_THR  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_MAX_CAND = cfg_idx_t'(1);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x_min;
		coord_t y_min;
		coord_t x_max;
		coord_t y_max;
	} box_t;

	typedef struct packed {
		box_t              box;
		logic [AREA_W-1:0] area;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic busy;
	} iou_status_t;

	// coordinate from a port field, sign taken from bit COORD_W-1
	function automatic coord_t coord_of(input logic [FIELD_W-1:0] f);
		coord_t c;
		c = '0;
		for (int i = 0; i < COORD_W; i++) begin
			if (i < FIELD_W) begin
				c[i] = f[i];
			end
		end
		return c;
	endfunction

	// hi - lo, or zero when the span is empty
	function automatic logic [LEN_W-1:0] clamp_len(input coord_t lo, input coord_t hi);
		logic [LEN_W-1:0] d;
		d = LEN_W'(hi - lo);
		if ($signed(hi) > $signed(lo)) begin
			return d;
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

// ===== sv/gbn_store.sv =====
`default_nettype none

module gbn_store (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          we,
	input  wire  [gbn_pkg::IDX_W-1:0]    waddr,
	input  wire  gbn_pkg::entry_t        wdata,
	input  wire                          re,
	input  wire  [gbn_pkg::IDX_W-1:0]    raddr,
	output gbn_pkg::entry_t              rdata,
	output logic                         rvalid
);

	gbn_pkg::entry_t mem_q [gbn_pkg::MAX_KEPT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid <= 1'b0;
		end else begin
			rvalid <= re;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gbn_iou.sv =====
`default_nettype none

module gbn_iou (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire  gbn_pkg::entry_t            stored,
	input  wire  gbn_pkg::box_t              cand_box,
	input  wire  [gbn_pkg::AREA_W-1:0]       cand_area,
	input  wire  [gbn_pkg::THR_W-1:0]        thr,
	output gbn_pkg::iou_status_t             st
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	gbn_pkg::coord_t             l_s1, t_s1, r_s1, d_s1;
	logic [gbn_pkg::AREA_W-1:0]  area_b_s1, area_b_s2, area_b_s3;
	logic [gbn_pkg::LEN_W-1:0]   w_s2, h_s2;
	logic [gbn_pkg::AREA_W-1:0]  inter_s3, inter_s4;
	logic [gbn_pkg::UNION_W-1:0] union_s4;
	logic [gbn_pkg::LHS_W-1:0]   lhs_s5;
	logic [gbn_pkg::RHS_W-1:0]   rhs_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// overlap rectangle
		l_s1 <= ($signed(cand_box.x_min) > $signed(stored.box.x_min)) ?
			cand_box.x_min : stored.box.x_min;
		t_s1 <= ($signed(cand_box.y_min) > $signed(stored.box.y_min)) ?
			cand_box.y_min : stored.box.y_min;
		r_s1 <= ($signed(cand_box.x_max) < $signed(stored.box.x_max)) ?
			cand_box.x_max : stored.box.x_max;
		d_s1 <= ($signed(cand_box.y_max) < $signed(stored.box.y_max)) ?
			cand_box.y_max : stored.box.y_max;
		area_b_s1 <= stored.area;

		w_s2      <= gbn_pkg::clamp_len(l_s1, r_s1);
		h_s2      <= gbn_pkg::clamp_len(t_s1, d_s1);
		area_b_s2 <= area_b_s1;

		inter_s3  <= gbn_pkg::AREA_W'(w_s2) * gbn_pkg::AREA_W'(h_s2);
		area_b_s3 <= area_b_s2;

		// union never goes negative since inter is at most either area
		union_s4 <= gbn_pkg::UNION_W'(cand_area) + gbn_pkg::UNION_W'(area_b_s3)
			- gbn_pkg::UNION_W'(inter_s3);
		inter_s4 <= inter_s3;

		lhs_s5 <= gbn_pkg::LHS_W'(inter_s4) << gbn_pkg::THR_W;
		rhs_s5 <= gbn_pkg::RHS_W'(union_s4) * gbn_pkg::RHS_W'(thr);
	end

	assign st.hit  = v_s5 && (gbn_pkg::RHS_W'(lhs_s5) > rhs_s5);
	assign st.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule

`default_nettype wire

// ===== sv/greedy_box_nms_core.sv =====
`default_nettype none

// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata boxes, s_tlast group end
// m_        out  m_tvalid / m_tready       m_tdata echoes, m_tuser kept, m_tlast
// cfg_      in   cfg_we (no wait)          cfg_index, cfg_data
//
// an accepted item runs len, area, scan (one kept entry per cycle into the five-stage
// iou unit), drain until that unit empties, and finish, which loads the result register
// once it is free; a dropped box or an empty list skips scan and drain
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register and the next item may already be accepted
// reset clears the counters and loads the config defaults; the kept store needs no
// clearing pass, only entries below kept_count are read
module greedy_box_nms_core (
	input  wire                             clk,
	input  wire                             arst_n,
	// fields from bit 0: x_min, y_min, x_max, y_max, score, label
	input  wire  [gbn_pkg::TDATA_W-1:0]     s_tdata,
	input  wire                             s_tlast,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: out_x_min, out_y_min, out_x_max, out_y_max,
	// out_score, out_label
	output logic [gbn_pkg::TDATA_W-1:0]     m_tdata,
	// fields from bit 0: kept
	output logic                            m_tuser,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	input  wire                             cfg_we,
	input  wire  [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [gbn_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_AREA,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// config
	logic [gbn_pkg::THR_W-1:0]  thr_q;
	logic [gbn_pkg::MAXC_W-1:0] max_cand_q;

	// group counters
	logic [gbn_pkg::CNT_W-1:0]  kept_count_q;
	logic [gbn_pkg::SEEN_W-1:0] seen_q;

	// current item
	gbn_pkg::box_t                 box_q;
	logic [gbn_pkg::TDATA_W-1:0]   echo_q;
	logic                          last_q;
	logic [gbn_pkg::LEN_W-1:0]     len_w_q, len_h_q;
	logic [gbn_pkg::AREA_W-1:0]    area_q;
	logic                          eligible_q;
	logic                          hit_q;
	logic [gbn_pkg::IDX_W-1:0]     scan_idx_q;

	gbn_pkg::entry_t      wr_entry;
	gbn_pkg::entry_t      rd_entry;
	logic                 rd_valid;
	logic                 store_we;
	logic                 store_re;
	gbn_pkg::iou_status_t iou_st;

	logic s_acc;
	logic out_free;
	logic keep_now;
	logic scan_last;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	// a survivor with a full list is reported as dropped
	assign keep_now  = eligible_q && !hit_q &&
		(kept_count_q < gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT));
	assign scan_last = (gbn_pkg::CNT_W'(scan_idx_q) + gbn_pkg::CNT_W'(1)) == kept_count_q;

	assign store_we = (state_q == ST_FINISH) && out_free && keep_now;
	assign store_re = (state_q == ST_SCAN);

	assign wr_entry.box  = box_q;
	assign wr_entry.area = area_q;

	gbn_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (store_we),
		.waddr  (kept_count_q[gbn_pkg::IDX_W-1:0]),
		.wdata  (wr_entry),
		.re     (store_re),
		.raddr  (scan_idx_q),
		.rdata  (rd_entry),
		.rvalid (rd_valid)
	);

	gbn_iou u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_valid),
		.stored    (rd_entry),
		.cand_box  (box_q),
		.cand_area (area_q),
		.thr       (thr_q),
		.st        (iou_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thr_q        <= gbn_pkg::THR_RESET;
			max_cand_q   <= gbn_pkg::MAXC_RESET;
			kept_count_q <= '0;
			seen_q       <= '0;
			box_q        <= '0;
			echo_q       <= '0;
			last_q       <= 1'b0;
			len_w_q      <= '0;
			len_h_q      <= '0;
			area_q       <= '0;
			eligible_q   <= 1'b0;
			hit_q        <= 1'b0;
			scan_idx_q   <= '0;
			m_tdata      <= '0;
			m_tuser      <= 1'b0;
			m_tlast      <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gbn_pkg::CFG_IOU_THR:  thr_q      <= cfg_data[gbn_pkg::THR_W-1:0];
					gbn_pkg::CFG_MAX_CAND: max_cand_q <= cfg_data[gbn_pkg::MAXC_W-1:0];
					default: ;
				endcase
			end

			// any hit from the iou pipe suppresses the box
			if (iou_st.hit) begin
				hit_q <= 1'b1;
			end

			// a result taken while the next one loads is replaced below
			if (m_tvalid && m_tready && !((state_q == ST_FINISH) && out_free)) begin
				m_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						box_q.x_min <= gbn_pkg::coord_of(s_tdata[0 +: gbn_pkg::FIELD_W]);
						box_q.y_min <= gbn_pkg::coord_of(
							s_tdata[gbn_pkg::FIELD_W +: gbn_pkg::FIELD_W]);
						box_q.x_max <= gbn_pkg::coord_of(
							s_tdata[2*gbn_pkg::FIELD_W +: gbn_pkg::FIELD_W]);
						box_q.y_max <= gbn_pkg::coord_of(
							s_tdata[3*gbn_pkg::FIELD_W +: gbn_pkg::FIELD_W]);
						echo_q  <= gbn_pkg::TDATA_W'(s_tdata[gbn_pkg::PAYLOAD_W-1:0]);
						last_q  <= s_tlast;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_w_q <= gbn_pkg::clamp_len(box_q.x_min, box_q.x_max);
					len_h_q <= gbn_pkg::clamp_len(box_q.y_min, box_q.y_max);
					state_q <= ST_AREA;
				end
				ST_AREA: begin
					area_q     <= gbn_pkg::AREA_W'(len_w_q) * gbn_pkg::AREA_W'(len_h_q);
					eligible_q <= gbn_pkg::MAXC_W'(seen_q) < max_cand_q;
					hit_q      <= 1'b0;
					scan_idx_q <= '0;
					// dropped boxes and an empty list skip the scan
					if ((gbn_pkg::MAXC_W'(seen_q) < max_cand_q) && (kept_count_q != '0)) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + gbn_pkg::IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid && !iou_st.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata  <= echo_q;
						m_tuser  <= keep_now;
						m_tlast  <= last_q;
						m_tvalid <= 1'b1;
						if (last_q) begin
							kept_count_q <= '0;
							seen_q       <= '0;
						end else begin
							if (keep_now) begin
								kept_count_q <= kept_count_q + gbn_pkg::CNT_W'(1);
							end
							if (seen_q != gbn_pkg::SEEN_MAX) begin
								seen_q <= seen_q + gbn_pkg::SEEN_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// kept list never grows past its depth
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT))
		else $error("kept count above list depth");

	// no comparison is in flight once the sequencer is idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!iou_st.busy && !rd_valid))
		else $error("iou pipe busy while idle");

	// an accepted item holds off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("ready right after accept");

	// the store is never written while a scan reads it
	a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> (!store_re && !rd_valid && !iou_st.busy))
		else $error("store written during scan");

endmodule

`default_nettype wire

// ===== bench/tb_greedy_box_nms_core.sv =====
`default_nettype none

// greedy box nms core: boxes stream in with their group end on tlast, and for
// each box one result comes out that echoes it, with the kept flag on tuser.
// a model of the suppression state runs beside the block. every accepted box
// is decided there and the result is queued, and every result leaving the
// block is checked against the oldest one waiting.
module tb_greedy_box_nms_core;

	localparam int WATCHDOG_CYCLES = 4000;   // cycles with no item moving on either side
	localparam int RX_HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int DRAIN_CYCLES    = 200;    // more than one full scan of the kept list

	// one box as it travels in, plus its group end flag
	typedef struct packed {
		gbn_pkg::coord_t x_min;
		gbn_pkg::coord_t y_min;
		gbn_pkg::coord_t x_max;
		gbn_pkg::coord_t y_max;
		logic [15:0]     score;
		logic [7:0]      label;
		logic            last;
	} box_item_t;

	// what the block should send back for one box
	typedef struct packed {
		logic      kept;
		box_item_t item;
	} nms_result_t;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	// from bit 0: x_min, y_min, x_max, y_max, score, label
	logic [gbn_pkg::TDATA_W-1:0]     s_tdata   = '0;
	logic                            s_tlast   = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	// from bit 0: out_x_min, out_y_min, out_x_max, out_y_max, out_score, out_label
	logic [gbn_pkg::TDATA_W-1:0]     m_tdata;
	// from bit 0: kept
	logic                            m_tuser;
	logic                            m_tlast;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	greedy_box_nms_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// boxes waiting to be driven, and results waiting to come out
	box_item_t   pending_boxes [$];
	nms_result_t awaited_results [$];
	box_item_t   cur_box;
	nms_result_t sent_result;
	nms_result_t head_result;

	// suppression state of the model: kept list, counters, registers
	gbn_pkg::coord_t kx0 [gbn_pkg::MAX_KEPT];
	gbn_pkg::coord_t ky0 [gbn_pkg::MAX_KEPT];
	gbn_pkg::coord_t kx1 [gbn_pkg::MAX_KEPT];
	gbn_pkg::coord_t ky1 [gbn_pkg::MAX_KEPT];
	longint unsigned karea [gbn_pkg::MAX_KEPT];
	int              kept_n   = 0;
	logic [7:0]      seen_n   = 8'd0;
	logic [15:0]     thr_cfg  = 16'd29491;   // 0.45 in q0.16
	logic [7:0]      maxc_cfg = 8'd100;

	// pacing of both sides, set per phase
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_reqs = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;

	int n_queued   = 0;
	int n_sent     = 0;
	int n_checked  = 0;
	int n_kept     = 0;
	int n_groups   = 0;
	int n_cfg      = 0;
	int n_errors   = 0;
	int quiet_cnt  = 0;

	// hi - lo when positive, else zero; the difference needs 17 bits
	function automatic logic [15:0] span(gbn_pkg::coord_t lo, gbn_pkg::coord_t hi);
		logic signed [16:0] diff;
		diff = hi - lo;
		return (hi > lo) ? diff[15:0] : 16'd0;
	endfunction

	// greedy decision for one box, updates the kept list and counters
	function automatic logic nms_decide(box_item_t b);
		gbn_pkg::coord_t x0, y0, x1, y1, l, t, r, d;
		longint unsigned area, inter, uni;
		logic            survive, keep;
		int              i;
		x0 = b.x_min;
		y0 = b.y_min;
		x1 = b.x_max;
		y1 = b.y_max;
		area = 64'(span(x0, x1));
		area = area * 64'(span(y0, y1));
		keep = 1'b0;
		// boxes past the candidate limit are dropped without a scan
		if (seen_n < maxc_cfg) begin
			survive = 1'b1;
			for (i = 0; i < kept_n && survive; i++) begin
				l = (x0 > kx0[i]) ? x0 : kx0[i];
				t = (y0 > ky0[i]) ? y0 : ky0[i];
				r = (x1 < kx1[i]) ? x1 : kx1[i];
				d = (y1 < ky1[i]) ? y1 : ky1[i];
				inter = 64'(span(l, r));
				inter = inter * 64'(span(t, d));
				uni = area + karea[i] - inter;
				// iou > thr without a divide; zero union never suppresses
				if ((inter << 16) > uni * 64'(thr_cfg)) begin
					survive = 1'b0;
				end
			end
			// a survivor with no room left counts as dropped
			if (survive && kept_n < gbn_pkg::MAX_KEPT) begin
				kx0[kept_n]   = x0;
				ky0[kept_n]   = y0;
				kx1[kept_n]   = x1;
				ky1[kept_n]   = y1;
				karea[kept_n] = area;
				kept_n++;
				keep = 1'b1;
			end
		end
		if (seen_n != 8'hFF) begin
			seen_n++;
		end
		if (b.last) begin
			kept_n = 0;
			seen_n = 8'd0;
		end
		return keep;
	endfunction

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			n_errors++;
		end
	endfunction

	function automatic gbn_pkg::coord_t clip_coord(int v);
		if (v < -32768) begin
			v = -32768;
		end
		if (v > 32767) begin
			v = 32767;
		end
		return gbn_pkg::coord_t'(v);
	endfunction

	// driver: offers the next pending box when the slot is free, idling at random per tx_idle_pct
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				n_sent++;
				sent_result.item = cur_box;
				sent_result.kept = nms_decide(cur_box);
				awaited_results = {awaited_results, sent_result};
			end
			if (!s_tvalid || s_tready) begin
				if (pending_boxes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					cur_box = pending_boxes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_box.label, cur_box.score, cur_box.y_max,
						cur_box.x_max, cur_box.y_min, cur_box.x_min};
					s_tlast  <= cur_box.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off, counted here so the monitor only sees a flag
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_seen != rx_hold_reqs) begin
			rx_hold_seen <= rx_hold_reqs;
			rx_hold_left <= RX_HOLD_CYCLES;
		end
	end

	// monitor: checks each result against the oldest waiting one
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (m_tuser) begin
					n_kept++;
				end
				if (awaited_results.size() == 0) begin
					$error("result with no box waiting for it");
					n_errors++;
				end else begin
					head_result = awaited_results.pop_front();
					check_field("kept", int'(head_result.kept), int'(m_tuser));
					check_field("out_x_min", int'(head_result.item.x_min),
						int'($signed(m_tdata[15:0])));
					check_field("out_y_min", int'(head_result.item.y_min),
						int'($signed(m_tdata[31:16])));
					check_field("out_x_max", int'(head_result.item.x_max),
						int'($signed(m_tdata[47:32])));
					check_field("out_y_max", int'(head_result.item.y_max),
						int'($signed(m_tdata[63:48])));
					check_field("out_score", int'(head_result.item.score),
						int'(m_tdata[79:64]));
					check_field("out_label", int'(head_result.item.label),
						int'(m_tdata[87:80]));
					check_field("out_group_end", int'(head_result.item.last),
						int'(m_tlast));
				end
			end
			m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// watchdog on cycles where no item moves
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= WATCHDOG_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	task automatic queue_box(gbn_pkg::coord_t x0, gbn_pkg::coord_t y0,
		gbn_pkg::coord_t x1, gbn_pkg::coord_t y1,
		logic [15:0] sc, logic [7:0] lb, logic last);
		box_item_t b;
		b.x_min = x0;
		b.y_min = y0;
		b.x_max = x1;
		b.y_max = y1;
		b.score = sc;
		b.label = lb;
		b.last  = last;
		pending_boxes = {pending_boxes, b};
		n_queued++;
		if (last) begin
			n_groups++;
		end
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(gbn_pkg::cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
		if (idx == gbn_pkg::CFG_IOU_THR) begin
			thr_cfg = val;
		end else begin
			maxc_cfg = val[7:0];
		end
	endtask

	task automatic wait_drained();
		while (n_checked != n_queued) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_pace(int tx_pct, int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// one group of n boxes; unless fresh_only, about half sit close to the previous box so that
	// suppression is exercised; now and then the group end is left off
	task automatic gen_group(int n, bit fresh_only);
		int              i, cx, cy, w, h, j;
		gbn_pkg::coord_t x0, y0, x1, y1, px0, py0, px1, py1;
		logic            last;
		px0 = '0;
		py0 = '0;
		px1 = '0;
		py1 = '0;
		w = 1;
		h = 1;
		for (i = 0; i < n; i++) begin
			if (i > 0 && !fresh_only && $urandom_range(99) < 50) begin
				j  = (w > h ? w : h) / 3 + 1;
				x0 = clip_coord(int'(px0) + int'($urandom_range(2 * j)) - j);
				y0 = clip_coord(int'(py0) + int'($urandom_range(2 * j)) - j);
				x1 = clip_coord(int'(px1) + int'($urandom_range(2 * j)) - j);
				y1 = clip_coord(int'(py1) + int'($urandom_range(2 * j)) - j);
			end else if ($urandom_range(99) < 15) begin
				// raw bits, often inverted or huge
				x0 = gbn_pkg::coord_t'($urandom);
				y0 = gbn_pkg::coord_t'($urandom);
				x1 = gbn_pkg::coord_t'($urandom);
				y1 = gbn_pkg::coord_t'($urandom);
				w  = 4096;
				h  = 4096;
			end else begin
				cx = int'($urandom_range(65535)) - 32768;
				cy = int'($urandom_range(65535)) - 32768;
				w  = $urandom_range(3000);
				h  = $urandom_range(3000);
				x0 = clip_coord(cx - w / 2);
				y0 = clip_coord(cy - h / 2);
				x1 = clip_coord(cx + w - w / 2);
				y1 = clip_coord(cy + h - h / 2);
			end
			px0 = x0;
			py0 = y0;
			px1 = x1;
			py1 = y1;
			last = (i == n - 1) && ($urandom_range(99) < 92);
			queue_box(x0, y0, x1, y1, 16'($urandom), 8'($urandom), last);
		end
	endtask

	initial begin
		int ph, made, n, sel;
		logic [15:0] thr_v;
		logic [7:0]  maxc_v;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset settings first
		set_pace(13, 13);
		queue_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'hFFFF, 8'hFF, 1'b0);
		queue_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'h1234, 8'h01, 1'b0);
		queue_box(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h8000, 8'h80, 1'b0);
		// iou of exactly 0.45 sits just over the reset threshold
		queue_box(16'sd0, 16'sd0, 16'sd100, 16'sd45, 16'h7FFF, 8'h7F, 1'b0);
		queue_box(16'sd0, 16'sd0, 16'sd100, 16'sd44, 16'h5555, 8'h55, 1'b0);
		// zero width box, then the same again: zero union keeps it
		queue_box(16'sd200, 16'sd200, 16'sd200, 16'sd300, 16'hAAAA, 8'hAA, 1'b0);
		queue_box(16'sd200, 16'sd200, 16'sd200, 16'sd300, 16'h00FF, 8'h0F, 1'b0);
		// inverted boxes
		queue_box(16'sd500, 16'sd500, 16'sd400, 16'sd400, 16'hFF00, 8'hF0, 1'b0);
		queue_box(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'h0000, 8'h00, 1'b1);
		wait_drained();

		// one candidate per group: the second box is dropped
		write_reg(gbn_pkg::CFG_IOU_THR, 16'h0000);
		write_reg(gbn_pkg::CFG_MAX_CAND, 16'hA501);
		queue_box(16'sd10, 16'sd10, 16'sd20, 16'sd20, 16'h0101, 8'h11, 1'b0);
		queue_box(16'sd12, 16'sd12, 16'sd22, 16'sd22, 16'h0202, 8'h22, 1'b1);
		wait_drained();

		// zero threshold: any overlap suppresses, touching edges do not
		write_reg(gbn_pkg::CFG_MAX_CAND, 16'd128);
		queue_box(16'sd10, 16'sd10, 16'sd20, 16'sd20, 16'h0303, 8'h33, 1'b0);
		queue_box(16'sd19, 16'sd19, 16'sd30, 16'sd30, 16'h0404, 8'h44, 1'b0);
		queue_box(16'sd20, 16'sd20, 16'sd30, 16'sd30, 16'h0505, 8'h66, 1'b1);
		wait_drained();

		// top threshold: only an identical box is suppressed
		write_reg(gbn_pkg::CFG_IOU_THR, 16'hFFFF);
		queue_box(16'sd0, 16'sd0, 16'sd1000, 16'sd1000, 16'h0606, 8'h77, 1'b0);
		queue_box(16'sd0, 16'sd0, 16'sd1000, 16'sd1000, 16'h0707, 8'h88, 1'b0);
		queue_box(16'sd0, 16'sd0, 16'sd1000, 16'sd999, 16'h0808, 8'h99, 1'b1);
		wait_drained();

		// fill the kept list to the candidate limit, then drop the rest
		write_reg(gbn_pkg::CFG_MAX_CAND, 16'd128);
		gen_group(135, 1'b1);
		wait_drained();

		// random phases, each with its own settings and pacing
		for (ph = 0; ph < 4; ph++) begin
			sel = $urandom_range(3);
			case (sel)
				0: thr_v = 16'($urandom);
				1: thr_v = 16'($urandom_range(20000, 45000));
				2: thr_v = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
				default: thr_v = 16'd29491;
			endcase
			sel = $urandom_range(3);
			case (sel)
				0: maxc_v = 8'($urandom_range(1, 12));
				1: maxc_v = 8'd1;
				2: maxc_v = 8'd128;
				default: maxc_v = 8'($urandom_range(1, 128));
			endcase
			write_reg(gbn_pkg::CFG_IOU_THR, thr_v);
			write_reg(gbn_pkg::CFG_MAX_CAND, {8'($urandom), maxc_v});
			case (ph % 4)
				0: set_pace(0, 0);
				1: set_pace(66, 0);
				2: set_pace(0, 66);
				default: set_pace(13, 13);
			endcase
			made = 0;
			while (made < 20) begin
				n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
				gen_group(n, 1'b0);
				made += n;
			end
			wait_drained();
		end

		// back-pressure: receiver holds off while boxes keep coming
		write_reg(gbn_pkg::CFG_IOU_THR, 16'd29491);
		write_reg(gbn_pkg::CFG_MAX_CAND, 16'd100);
		set_pace(0, 0);
		rx_hold_reqs++;
		gen_group(20, 1'b0);
		wait_drained();

		// one long group past the seen counter saturation point
		write_reg(gbn_pkg::CFG_MAX_CAND, 16'd2);
		set_pace(0, 13);
		for (n = 0; n < 260; n++) begin
			queue_box(gbn_pkg::coord_t'($urandom_range(1000)),
				gbn_pkg::coord_t'($urandom_range(1000)),
				gbn_pkg::coord_t'($urandom_range(1000, 2000)),
				gbn_pkg::coord_t'($urandom_range(1000, 2000)),
				16'($urandom), 8'($urandom), n == 259);
		end
		wait_drained();

		// nothing more should leave the block
		set_pace(0, 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			n_errors++;
		end
		$display("covered %0d boxes in %0d closed groups, %0d results checked, %0d kept",
			n_sent, n_groups, n_checked, n_kept);
		$display("%0d register writes, thresholds 0 to max, limits 1 to 128, with hold-off",
			n_cfg);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
